@@ hw/rtl/tcp8_pkg.sv @@
// Package for the eight-bit timer/counter with PWM output.
// Holds the transaction structs, command and register codes, and the prescaler mask function.
// It depends on nothing else.
package tcp8_pkg;

   // Commands carried by one request transaction
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Register selects
   localparam logic [2:0] REG_CONTROL = 3'd0;
   localparam logic [2:0] REG_COUNT   = 3'd1;
   localparam logic [2:0] REG_COMPARE = 3'd2;
   localparam logic [2:0] REG_FLAGS   = 3'd3;
   localparam logic [2:0] REG_MASK    = 3'd4;

   // Timer modes, formed as {control bit 3, control bit 6}
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_PHASE  = 2'd1;
   localparam logic [1:0] MODE_CTC    = 2'd2;
   localparam logic [1:0] MODE_FAST   = 2'd3;

   // Compare output actions
   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_TOGGLE = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;
   localparam logic [1:0] ACT_SET    = 2'd3;

   // Clock select codes; every other code stops the timer
   localparam logic [2:0] CS_DIV1    = 3'd1;
   localparam logic [2:0] CS_DIV8    = 3'd2;
   localparam logic [2:0] CS_DIV64   = 3'd3;
   localparam logic [2:0] CS_DIV256  = 3'd4;
   localparam logic [2:0] CS_DIV1024 = 3'd5;

   localparam int unsigned PRESCALE_W = 10;

   typedef struct packed {
      logic [1:0] command;
      logic [2:0] reg_select;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       wave_out;
      logic       overflow_irq;
      logic       compare_irq;
   } rsp_type;

   // Low prescaler bits that must all be ones for the count to step.
   function automatic logic [PRESCALE_W-1:0] div_mask(input logic [2:0] cs);
      logic [PRESCALE_W-1:0] m;
      case (cs)
         CS_DIV1:    m = 10'h000;
         CS_DIV8:    m = 10'h007;
         CS_DIV64:   m = 10'h03F;
         CS_DIV256:  m = 10'h0FF;
         CS_DIV1024: m = 10'h3FF;
         default:    m = 10'h000;
      endcase
      return m;
   endfunction

   // True when the clock select names a divider.
   function automatic logic clock_running(input logic [2:0] cs);
      logic r;
      case (cs)
         CS_DIV1, CS_DIV8, CS_DIV64, CS_DIV256, CS_DIV1024: r = 1'b1;
         default:                                          r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/timer_counter_pwm_8bit_unit.sv @@
// Top level of the eight-bit timer/counter with compare output and PWM.
// Input register, single-pass update logic and result register in one module.
// Depends on tcp8_pkg.
//
// Usage:
//   The request channel (req_valid, req_ready, req_data) carries one transaction per
//   system clock tick or register access: command 0 is a tick, 1 a register write and
//   2 a register read. The response channel (rsp_valid, rsp_ready, rsp_data) returns
//   exactly one transaction for each request, in order: the read byte (zero unless a
//   read), the compare pin level and the two interrupt lines after that request.
//   A request is captured in an input register; once the output register is free or
//   being emptied, it updates the timer state and its response is loaded into the
//   output register. One request per cycle is sustained while the receiver takes each
//   response; the figure is set by the single update stage between the input
//   register and the output register.
//   When the receiver stalls, the output register holds its transaction, the input
//   register holds one more, and req_ready falls until the output is taken.
//   Synchronous reset clears all timer registers (timer stopped, count and compare
//   zero, flags and enables clear, pin low) and empties both registers.
module timer_counter_pwm_8bit_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcp8_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcp8_pkg::rsp_type rsp_data
);
   import tcp8_pkg::*;

   // Pipeline registers
   logic     in_valid_ff;
   req_type  in_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_ff;
   rsp_type  rsp_in;

   // Timer state
   logic [6:0]            control_ff, control_in;
   logic [7:0]            count_ff, count_in;
   logic [7:0]            compare_ff, compare_in;
   logic [PRESCALE_W-1:0] prescale_ff, prescale_in;
   logic                  ovf_flag_ff, ovf_flag_in;
   logic                  cmp_flag_ff, cmp_flag_in;
   logic [1:0]            irq_en_ff, irq_en_in;
   logic                  down_ff, down_in;
   logic                  pin_ff, pin_in;

   // Decoded fields and intermediate terms
   logic                  advance;
   logic                  is_tick;
   logic                  step_en;
   logic [1:0]            mode;
   logic [1:0]            action;
   logic [1:0]            new_action;
   logic [2:0]            clk_sel;
   logic                  match;
   logic                  pc_down;
   logic                  up_level;
   logic [PRESCALE_W-1:0] pmask;
   logic [7:0]            read_byte;

   // Handshake: the stage moves when the output register is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Control decode
   assign mode       = {control_ff[3], control_ff[6]};
   assign action     = control_ff[5:4];
   assign new_action = in_ff.write_data[5:4];
   assign clk_sel    = control_ff[2:0];
   assign pmask      = div_mask(clk_sel);
   assign is_tick    = in_ff.command == CMD_TICK;
   assign step_en    = is_tick && clock_running(clk_sel) && ((prescale_ff & pmask) == pmask);
   assign match      = count_ff == compare_ff;
   assign up_level   = action == ACT_SET;

   // Phase-correct direction for this step
   always_comb begin
      if (count_ff == 8'hFF) begin
         pc_down = 1'b1;
      end else if (count_ff == 8'h00) begin
         pc_down = 1'b0;
      end else begin
         pc_down = down_ff;
      end
   end

   // Next timer state for the transaction in the input register
   always_comb begin
      control_in  = control_ff;
      count_in    = count_ff;
      compare_in  = compare_ff;
      prescale_in = prescale_ff;
      ovf_flag_in = ovf_flag_ff;
      cmp_flag_in = cmp_flag_ff;
      irq_en_in   = irq_en_ff;
      down_in     = down_ff;
      pin_in      = pin_ff;
      read_byte   = 8'h00;

      case (in_ff.command)
         CMD_TICK: begin
            if (clock_running(clk_sel)) begin
               prescale_in = prescale_ff + PRESCALE_W'(1);
            end
            if (step_en) begin
               if (match) begin
                  cmp_flag_in = 1'b1;
               end
               if (mode == MODE_PHASE) begin
                  down_in = pc_down;
                  if (match && action[1]) begin
                     pin_in = pc_down ? !up_level : up_level;
                  end
                  count_in = pc_down ? count_ff - 8'd1 : count_ff + 8'd1;
                  if (pc_down && count_ff == 8'h01) begin
                     ovf_flag_in = 1'b1;
                  end
               end else begin
                  down_in = 1'b0;
                  if (mode == MODE_CTC && match) begin
                     count_in = 8'h00;
                  end else begin
                     count_in = count_ff + 8'd1;
                     if (count_ff == 8'hFF) begin
                        ovf_flag_in = 1'b1;
                     end
                  end
                  if (mode == MODE_FAST) begin
                     // The wrap to zero acts after the match
                     if (action[1]) begin
                        if (match) begin
                           pin_in = up_level;
                        end
                        if (count_ff == 8'hFF) begin
                           pin_in = !up_level;
                        end
                     end
                  end else if (match) begin
                     case (action)
                        ACT_TOGGLE: pin_in = !pin_ff;
                        ACT_CLEAR:  pin_in = 1'b0;
                        ACT_SET:    pin_in = 1'b1;
                        default:    pin_in = pin_ff;
                     endcase
                  end
               end
            end
         end
         CMD_WRITE: begin
            case (in_ff.reg_select)
               REG_CONTROL: begin
                  control_in = in_ff.write_data[6:0];
                  // Force compare acts only in the non-PWM modes
                  if (in_ff.write_data[7] && !in_ff.write_data[6]) begin
                     case (new_action)
                        ACT_TOGGLE: pin_in = !pin_ff;
                        ACT_CLEAR:  pin_in = 1'b0;
                        ACT_SET:    pin_in = 1'b1;
                        default:    pin_in = pin_ff;
                     endcase
                  end
               end
               REG_COUNT:   count_in   = in_ff.write_data;
               REG_COMPARE: compare_in = in_ff.write_data;
               REG_FLAGS: begin
                  if (in_ff.write_data[0]) begin
                     ovf_flag_in = 1'b0;
                  end
                  if (in_ff.write_data[1]) begin
                     cmp_flag_in = 1'b0;
                  end
               end
               REG_MASK:    irq_en_in  = in_ff.write_data[1:0];
               default:     ;
            endcase
         end
         CMD_READ: begin
            case (in_ff.reg_select)
               REG_CONTROL: read_byte = {1'b0, control_ff};
               REG_COUNT:   read_byte = count_ff;
               REG_COMPARE: read_byte = compare_ff;
               REG_FLAGS:   read_byte = {6'b0, cmp_flag_ff, ovf_flag_ff};
               REG_MASK:    read_byte = {6'b0, irq_en_ff};
               default:     read_byte = 8'h00;
            endcase
         end
         default: ;
      endcase
   end

   // Response built from the updated state
   always_comb begin
      rsp_in.read_data    = read_byte;
      rsp_in.wave_out     = pin_in;
      rsp_in.overflow_irq = ovf_flag_in & irq_en_in[0];
      rsp_in.compare_irq  = cmp_flag_in & irq_en_in[1];
   end

   // Pipeline control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Pipeline payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Timer state registers, updated once per processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff  <= '0;
         count_ff    <= '0;
         compare_ff  <= '0;
         prescale_ff <= '0;
         ovf_flag_ff <= 1'b0;
         cmp_flag_ff <= 1'b0;
         irq_en_ff   <= '0;
         down_ff     <= 1'b0;
         pin_ff      <= 1'b0;
      end else if (advance) begin
         control_ff  <= control_in;
         count_ff    <= count_in;
         compare_ff  <= compare_in;
         prescale_ff <= prescale_in;
         ovf_flag_ff <= ovf_flag_in;
         cmp_flag_ff <= cmp_flag_in;
         irq_en_ff   <= irq_en_in;
         down_ff     <= down_in;
         pin_ff      <= pin_in;
      end
   end

   // A pending response always reflects the current interrupt state and pin.
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.wave_out == pin_ff)
                    && (rsp_ff.overflow_irq == (ovf_flag_ff & irq_en_ff[0]))
                    && (rsp_ff.compare_irq == (cmp_flag_ff & irq_en_ff[1])))
      else $error("response disagrees with timer state");

   // A step outside phase-correct mode leaves the count direction up.
   a_down_only_phase: assert property (@(posedge clock) disable iff (reset)
      (advance && step_en && mode != MODE_PHASE) |=> !down_ff)
      else $error("count direction set outside phase-correct mode");

   // A stopped clock select freezes the prescaler.
   a_prescale_stopped: assert property (@(posedge clock) disable iff (reset)
      (advance && is_tick && !clock_running(clk_sel)) |=> $stable(prescale_ff))
      else $error("prescaler moved while the clock is stopped");

   // A held request is neither dropped nor processed twice.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_ff))
      else $error("input register lost a stalled transaction");

endmodule
